[design/exptok_pkg.sv]
// Shared types, constants and character classes for the expression tokenizer.
package exptok_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int TOK_WIDTH     = 16;
	localparam int FIFO_DEPTH    = 4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]           token_kind;
		logic [TOK_WIDTH-1:0] token_start;
		logic [TOK_WIDTH-1:0] token_length;
		logic [7:0]           lead_byte;
		logic                 last_of_run;
		logic                 pos_overflow;
	} token_t;

	// Results of one accepted item on their way into the output queue
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	localparam logic [2:0] KIND_END     = 3'd0;
	localparam logic [2:0] KIND_NUMBER  = 3'd1;
	localparam logic [2:0] KIND_IDENT   = 3'd2;
	localparam logic [2:0] KIND_OPER    = 3'd3;
	localparam logic [2:0] KIND_LPAREN  = 3'd4;
	localparam logic [2:0] KIND_RPAREN  = 3'd5;
	localparam logic [2:0] KIND_COMMA   = 3'd6;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	// Space, tab, LF, VT, FF and CR
	function automatic logic is_space(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
	endfunction

endpackage

[design/exptok_lexer.sv]
// Lexer state registers and the per-byte token decision logic.
module exptok_lexer #(
	parameter int POS_WIDTH = exptok_pkg::POS_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  exptok_pkg::item_t  item,
	output exptok_pkg::push_t  push
);
	import exptok_pkg::*;

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_NUM    = 5'b00010,
		MODE_NUMDOT = 5'b00100,
		MODE_IDENT  = 5'b01000,
		MODE_PEND   = 5'b10000
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;
	logic [POS_WIDTH-1:0] start_q, start_d;
	logic [7:0]           lead_q, lead_d;
	logic                 ovf_q, ovf_d;

	logic [7:0]           b;
	logic [POS_WIDTH-1:0] open_len;
	logic                 flush_ok;
	token_t               flush_tok;
	logic                 use_flush;
	logic                 start_ok;
	token_t               start_tok;
	logic                 cont;
	logic                 flag;
	logic [1:0]           n_res;

	assign b        = item.char_byte;
	assign open_len = pos_q - start_q;

	// Token that closes out whatever is open
	always_comb begin
		flush_ok               = 1'b0;
		flush_tok              = '0;
		flush_tok.token_start  = TOK_WIDTH'(start_q);
		flush_tok.token_length = TOK_WIDTH'(open_len);
		flush_tok.lead_byte    = lead_q;
		case (mode_q)
			MODE_NUM, MODE_NUMDOT: begin
				flush_ok             = 1'b1;
				flush_tok.token_kind = KIND_NUMBER;
			end
			MODE_IDENT: begin
				flush_ok             = 1'b1;
				flush_tok.token_kind = KIND_IDENT;
			end
			MODE_PEND: begin
				flush_ok               = 1'b1;
				flush_tok.token_kind   = KIND_UNKNOWN;
				flush_tok.token_length = TOK_WIDTH'(1);
				flush_tok.lead_byte    = CH_DOT;
			end
			default: flush_ok = 1'b0;
		endcase
	end

	always_comb begin
		mode_d                 = mode_q;
		pos_d                  = pos_q;
		start_d                = start_q;
		lead_d                 = lead_q;
		ovf_d                  = ovf_q;
		use_flush              = 1'b0;
		start_ok               = 1'b0;
		cont                   = 1'b0;
		start_tok              = '0;
		start_tok.token_kind   = KIND_UNKNOWN;
		start_tok.token_start  = TOK_WIDTH'(pos_q);
		start_tok.token_length = TOK_WIDTH'(1);
		start_tok.lead_byte    = b;
		if (item.cmd) begin
			use_flush              = flush_ok;
			start_ok               = 1'b1;
			start_tok.token_kind   = KIND_END;
			start_tok.token_length = '0;
			start_tok.lead_byte    = '0;
			flag                   = ovf_q;
			mode_d                 = MODE_IDLE;
			pos_d                  = '0;
			start_d                = '0;
			lead_d                 = '0;
			ovf_d                  = 1'b0;
		end else begin
			case (mode_q)
				MODE_NUM: begin
					cont = is_digit(b) || (b == CH_DOT);
					if (b == CH_DOT) mode_d = MODE_NUMDOT;
				end
				MODE_NUMDOT: cont = is_digit(b);
				MODE_IDENT:  cont = is_word(b);
				MODE_PEND: begin
					cont = is_digit(b);
					if (cont) mode_d = MODE_NUMDOT;
				end
				default: begin
					mode_d = MODE_IDLE;
					cont   = 1'b0;
				end
			endcase
			if (!cont) begin
				use_flush = flush_ok;
				mode_d    = MODE_IDLE;
				if (is_space(b)) begin
					start_ok = 1'b0;
				end else if (is_digit(b) || is_alpha(b) || b == CH_DOT || b == CH_UNDER) begin
					if (is_digit(b))      mode_d = MODE_NUM;
					else if (b == CH_DOT) mode_d = MODE_PEND;
					else                  mode_d = MODE_IDENT;
					start_d = pos_q;
					lead_d  = b;
				end else begin
					start_ok = 1'b1;
					if (b inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH})
						start_tok.token_kind = KIND_OPER;
					else if (b == CH_LPAR)
						start_tok.token_kind = KIND_LPAREN;
					else if (b == CH_RPAR)
						start_tok.token_kind = KIND_RPAREN;
					else if (b == CH_COMMA)
						start_tok.token_kind = KIND_COMMA;
					else
						start_tok.token_kind = KIND_UNKNOWN;
				end
			end
			// Saturate the position at the top of its range
			if (pos_q == POS_MAX) ovf_d = 1'b1;
			else                  pos_d = pos_q + POS_WIDTH'(1);
			flag = ovf_d;
		end
	end

	always_comb begin
		n_res                     = accept ? (2'(use_flush) + 2'(start_ok)) : 2'd0;
		push.count                = n_res;
		push.first                = use_flush ? flush_tok : start_tok;
		push.first.last_of_run    = (n_res == 2'd1);
		push.first.pos_overflow   = flag;
		push.second               = start_tok;
		push.second.last_of_run   = 1'b1;
		push.second.pos_overflow  = flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			lead_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			lead_q  <= lead_d;
			ovf_q   <= ovf_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd |=> mode_q == MODE_IDLE && pos_q == '0 && !ovf_q)
		else $error("state not cleared after end of input");
	a_byte_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.cmd |=> pos_q != '0)
		else $error("position not advanced after a byte");
	a_ovf_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> pos_q == POS_MAX)
		else $error("overflow flagged below the top position");
	a_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two tokens from one item");
`endif

endmodule

[design/exptok_fifo.sv]
// Small token queue that takes up to two tokens per cycle and hands out one while out_stall is low.
module exptok_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  exptok_pkg::push_t  push,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output exptok_pkg::token_t out_tok
);
	import exptok_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	token_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   rd_q, wr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;
	logic [PTR_W-1:0]   wr_next;

	// Hold off new items unless room for two tokens remains
	assign full      = cnt_q > CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_tok   = slot_q[rd_q];
	assign wr_next   = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) slot_q[wr_q]    <= push.first;
		if (push.count == 2'd2) slot_q[wr_next] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + PTR_W'(1);
			wr_q  <= wr_q + PTR_W'(push.count);
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue count past its depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> !full)
		else $error("tokens pushed while queue full");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + CNT_W'($past(push.count)) - CNT_W'($past(pop)))
		else $error("queue count out of step with pushes and pops");
`endif

endmodule

[design/expression_tokenizer.sv]
// Top level of the streaming arithmetic expression tokenizer.
//
//   channel | direction | handshake                 | payload
//   item    | in        | item_valid / item_stall   | item  (cmd, char_byte)
//   token   | out       | token_valid / token_stall | token (kind, start, length, lead, flags)
//
// One item is taken per clock while item_stall is low; its tokens are decided in the same
// cycle and written to a four-entry output queue, which delivers one token per clock while
// token_stall is low. An item that yields two tokens needs two output slots, so the queue
// sets the sustained rate: one item per cycle while items yield at most one token each.
// item_stall rises when fewer than two queue entries are free.
// Reset clears the lexer mode, position, open token and overflow flag, and empties the queue.
module expression_tokenizer #(
	parameter int POS_WIDTH = exptok_pkg::POS_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  exptok_pkg::item_t  item,
	output logic               token_valid,
	input  logic               token_stall,
	output exptok_pkg::token_t token
);
	import exptok_pkg::*;

	logic  accept;
	logic  full;
	push_t push;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	exptok_lexer #(
		.POS_WIDTH(POS_WIDTH)
	) u_lexer (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.push  (push)
	);

	exptok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.out_valid(token_valid),
		.out_stall(token_stall),
		.out_tok  (token)
	);

endmodule

[tb/tb_expression_tokenizer.sv]
// Self-checking testbench for the expression tokenizer: directed bytes, overflow run, random text.
module tb_expression_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import exptok_pkg::*;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   item_valid  = 1'b0;
	logic   item_stall;
	item_t  item_bus    = '0;
	logic   token_valid;
	logic   token_stall = 1'b0;
	token_t token_bus;

	bit quiet      = 1'b0;
	int stall_hold = 0;
	int items_sent = 0;

	always #5 clk = ~clk;

	expression_tokenizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item_bus),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token_bus)
	);

	class token_scoreboard;
		typedef enum logic [2:0] {
			LX_IDLE, LX_NUM, LX_NUMDOT, LX_IDENT, LX_PEND
		} lex_mode_e;

		lex_mode_e   mode;
		logic [15:0] pos;
		logic [15:0] tok_start;
		logic [7:0]  tok_lead;
		logic        ovf;
		token_t      expected_q[$];
		token_t      fresh[$];
		int          errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			mode      = LX_IDLE;
			pos       = '0;
			tok_start = '0;
			tok_lead  = '0;
			ovf       = 1'b0;
		endfunction

		function bit digit_ch(logic [7:0] b);
			return b >= 8'h30 && b <= 8'h39;
		endfunction

		function bit alpha_ch(logic [7:0] b);
			return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
		endfunction

		function bit blank_ch(logic [7:0] b);
			return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
		endfunction

		function bit word_ch(logic [7:0] b);
			return alpha_ch(b) || digit_ch(b) || b == CH_UNDER;
		endfunction

		function void emit(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
			logic [7:0] lead);
			token_t t;
			t              = '0;
			t.token_kind   = kind;
			t.token_start  = start;
			t.token_length = len;
			t.lead_byte    = lead;
			fresh.push_back(t);
		endfunction

		function void close_open();
			logic [15:0] len;
			len = pos - tok_start;
			case (mode)
				LX_NUM, LX_NUMDOT: emit(KIND_NUMBER, tok_start, len, tok_lead);
				LX_IDENT:          emit(KIND_IDENT, tok_start, len, tok_lead);
				LX_PEND:           emit(KIND_UNKNOWN, tok_start, 16'd1, CH_DOT);
				default: ;
			endcase
			mode = LX_IDLE;
		endfunction

		function void open_token(logic [7:0] b);
			logic [2:0] kind;
			if (blank_ch(b))
				return;
			if (digit_ch(b) || alpha_ch(b) || b == CH_DOT || b == CH_UNDER) begin
				if (digit_ch(b))
					mode = LX_NUM;
				else if (b == CH_DOT)
					mode = LX_PEND;
				else
					mode = LX_IDENT;
				tok_start = pos;
				tok_lead  = b;
				return;
			end
			case (b)
				CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: kind = KIND_OPER;
				CH_LPAR:  kind = KIND_LPAREN;
				CH_RPAR:  kind = KIND_RPAREN;
				CH_COMMA: kind = KIND_COMMA;
				default:  kind = KIND_UNKNOWN;
			endcase
			emit(kind, pos, 16'd1, b);
		endfunction

		function void note_item(item_t it);
			logic       flag;
			bit         cont;
			logic [7:0] b;
			fresh.delete();
			b = it.char_byte;
			if (it.cmd) begin
				close_open();
				emit(KIND_END, pos, 16'd0, 8'd0);
				flag = ovf;
				clear();
			end else begin
				case (mode)
					LX_NUM: begin
						cont = digit_ch(b) || b == CH_DOT;
						if (b == CH_DOT)
							mode = LX_NUMDOT;
					end
					LX_NUMDOT: cont = digit_ch(b);
					LX_IDENT:  cont = word_ch(b);
					LX_PEND: begin
						cont = digit_ch(b);
						if (cont)
							mode = LX_NUMDOT;
					end
					default: begin
						mode = LX_IDLE;
						cont = 1'b0;
					end
				endcase
				if (!cont) begin
					close_open();
					open_token(b);
				end
				// saturate the position at its top value
				if (pos == '1)
					ovf = 1'b1;
				else
					pos = pos + 16'd1;
				flag = ovf;
			end
			foreach (fresh[k]) begin
				fresh[k].pos_overflow = flag;
				fresh[k].last_of_run  = (k == fresh.size() - 1);
				expected_q.push_back(fresh[k]);
			end
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected token kind=%0d start=%0d len=%0d lead=%h",
					$time, got.token_kind, got.token_start, got.token_length, got.lead_byte);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				$display("%0t: token mismatch: expected kind=%0d start=%0d len=%0d lead=%h last=%b ovf=%b",
					$time, want.token_kind, want.token_start, want.token_length,
					want.lead_byte, want.last_of_run, want.pos_overflow);
				$display("%0t:                 actual   kind=%0d start=%0d len=%0d lead=%h last=%b ovf=%b",
					$time, got.token_kind, got.token_start, got.token_length,
					got.lead_byte, got.last_of_run, got.pos_overflow);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	token_scoreboard sb;

	// Mostly short idle stretches, a few long ones
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (token_valid && !token_stall)
				sb.check_token(token_bus);
			if (item_valid && !item_stall)
				sb.note_item(item_bus);
		end
	end

	always @(posedge clk) begin
		int g;
		if (stall_hold > 0) begin
			token_stall <= 1'b1;
			stall_hold  <= stall_hold - 1;
		end else begin
			g = idle_len();
			token_stall <= (g > 0);
			stall_hold  <= (g > 0) ? g - 1 : 0;
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] b);
		int    g;
		item_t it;
		g = idle_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		it.cmd       = cmd;
		it.char_byte = b;
		item_valid <= 1'b1;
		item_bus   <= it;
		@(posedge clk);
		// hold the request until the block takes it
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b);
	endtask

	task automatic send_end();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		// let the monitor note the last accepted request first
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r == 52)
			return CH_UNDER;
		if (r < 26)
			return 8'h61 + 8'(r);
		return 8'h41 + 8'(r - 26);
	endfunction

	function automatic logic [7:0] pick_word();
		return ($urandom_range(0, 2) == 0) ? pick_digit() : pick_letter();
	endfunction

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? 8'h20 : 8'h08 + 8'(r);
	endfunction

	function automatic logic [7:0] pick_oper();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic send_token();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				repeat ($urandom_range(1, 4)) send_byte(pick_digit());
				if ($urandom_range(0, 2) == 0) begin
					send_byte(CH_DOT);
					repeat ($urandom_range(0, 3)) send_byte(pick_digit());
				end
			end
			3: begin
				send_byte(CH_DOT);
				repeat ($urandom_range(1, 3)) send_byte(pick_digit());
			end
			4, 5: begin
				send_byte(pick_letter());
				repeat ($urandom_range(0, 6)) send_byte(pick_word());
			end
			6, 7: send_byte(pick_oper());
			8: send_byte($urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
			default: send_byte(CH_COMMA);
		endcase
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 2)) send_byte(pick_space());
	endtask

	task automatic send_broken();
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(0, 3))
				0: send_byte(CH_DOT);
				1: send_byte(pick_digit());
				2: send_byte(pick_space());
				default: send_byte(pick_letter());
			endcase
		end
	endtask

	initial begin
		string text;
		int    base;
		int    r;
		bit    paused;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// identifiers, operators, dotted numbers, a second dot, a lone dot, comma
		text = "_a9+(3.5)*.7-1.2./,";
		foreach (text[i])
			send_byte(text[i]);
		send_byte(8'h09);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_end();
		// a dot still pending at end of input
		send_byte(CH_DOT);
		send_end();
		item_valid <= 1'b0;
		drain();

		// run the position counter into saturation with a long token across it
		quiet = 1'b1;
		base  = items_sent;
		while (items_sent < base + 65500)
			send_token();
		send_byte(8'h78);
		repeat (80) send_byte(pick_word());
		repeat (20) send_token();
		send_end();
		quiet = 1'b0;

		base   = items_sent;
		paused = 1'b0;
		while (items_sent < base + 1800) begin
			if ($urandom_range(0, 9) == 0)
				quiet = ~quiet;
			if (!paused && items_sent > base + 900) begin
				item_valid <= 1'b0;
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(0, 9);
			if (r < 7) begin
				repeat ($urandom_range(1, 8)) send_token();
				send_end();
			end else if (r < 9) begin
				repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					send_end();
			end else begin
				send_broken();
				send_end();
			end
		end
		send_end();
		item_valid <= 1'b0;
		quiet = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
